FILE: design/fcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fcc_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int MAX_FILES   = 32;
	localparam int ADDR_W      = 12;
	localparam int FILE_W      = 5;

	typedef enum logic [1:0] {
		OP_LINK  = 2'd0,
		OP_FILE  = 2'd1,
		OP_CHECK = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// register indexes on the configuration port
	localparam logic [1:0] REG_BLOCK_SIZE    = 2'd0;
	localparam logic [1:0] REG_TABLE_ENTRIES = 2'd1;
	localparam logic [1:0] REG_FILE_COUNT    = 2'd2;

	// per-file issue flag bits
	localparam int FLAG_FEW   = 0;
	localparam int FLAG_MANY  = 1;
	localparam int FLAG_CYCLE = 2;
	localparam int FLAG_SHARE = 3;

endpackage
`default_nettype wire

FILE: design/fcc_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fcc_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [11:0]        slot;
	logic signed [12:0] next_link;
	logic signed [12:0] first_block;
	logic [30:0]        file_bytes;

	modport source (output valid, opcode, slot, next_link, first_block, file_bytes,
		input ready);
	modport sink (input valid, opcode, slot, next_link, first_block, file_bytes,
		output ready);
endinterface
`default_nettype wire

FILE: design/fcc_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fcc_res_if;
	logic        valid;
	logic        ready;
	logic [4:0]  file_index;
	logic        file_valid;
	logic        too_few_blocks;
	logic        too_many_blocks;
	logic        contains_cycle;
	logic        shares_blocks;
	logic [12:0] free_blocks;
	logic        last;

	modport source (output valid, file_index, file_valid, too_few_blocks,
		too_many_blocks, contains_cycle, shares_blocks, free_blocks, last,
		input ready);
	modport sink (input valid, file_index, file_valid, too_few_blocks,
		too_many_blocks, contains_cycle, shares_blocks, free_blocks, last,
		output ready);
endinterface
`default_nettype wire

FILE: design/fat_chain_consistency_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// fat chain consistency checker
// cmd channel takes one word per cycle while idle: opcode 0 loads one table
// link, opcode 1 loads one directory entry (first block, byte size), opcode 2
// starts a check. loads give no result.
// a check first clears the owner/visit marks of the entries in use, one entry
// per cycle, then walks every file's chain through the link and mark memories:
// for each block a registered memory read, then compare, mark write and one
// shared subtract of block_size.
// it then sends one res word per file (one word if the directory is empty),
// the last carrying the free block count. each res word waits in its output
// register until taken; a stalled receiver holds the block busy and cmd.ready
// stays low from the check command until the last word is taken.
// a further res word is built only once the one before it is taken.
// reset (arst_n low) restores the registers to their defaults and idles the
// block; table and directory contents are undefined until loaded.
// config is written over the apb port while idle: a rule for the user, which
// the block itself does not enforce; pready is always high.
module fat_chain_consistency_checker (
	input  wire         clk,
	input  wire         arst_n,
	fcc_cmd_if.sink     cmd,
	fcc_res_if.source   res,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		S_IDLE, S_CLEAR, S_FILE, S_WALK, S_LOOK, S_FINISH, S_EMIT, S_HOLD
	} state_t;

	state_t state_q;

	logic [10:0] block_size_q;
	logic [12:0] table_entries_q;
	logic [5:0]  file_count_q;

	logic [12:0]        idx_q;
	logic [12:0]        n_q;
	logic [5:0]         files_q;
	logic [5:0]         f_q;
	logic signed [12:0] cur_q;
	logic signed [32:0] rem_q;
	logic [12:0]        reached_q;
	logic [3:0]         flags_q [fcc_pkg::MAX_FILES];
	logic signed [12:0] start_q [fcc_pkg::MAX_FILES];
	logic [30:0]        len_q   [fcc_pkg::MAX_FILES];

	logic [12:0] link_mem [fcc_pkg::TABLE_DEPTH];
	logic [11:0] mark_mem [fcc_pkg::TABLE_DEPTH];
	logic [12:0] link_rd_q;
	logic [11:0] mark_rd_q;

	logic        out_valid_q;
	logic [4:0]  out_index_q;
	logic        out_fvalid_q;
	logic [3:0]  out_flags_q;
	logic [12:0] out_free_q;
	logic        out_last_q;

	// apb configuration
	logic       cfg_we;
	logic [1:0] reg_idx;
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			fcc_pkg::REG_BLOCK_SIZE:    prdata = {21'd0, block_size_q};
			fcc_pkg::REG_TABLE_ENTRIES: prdata = {19'd0, table_entries_q};
			fcc_pkg::REG_FILE_COUNT:    prdata = {26'd0, file_count_q};
			default:                    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q    <= 11'd512;
			table_entries_q <= 13'd4096;
			file_count_q    <= 6'd0;
		end else if (cfg_we) begin
			case (reg_idx)
				fcc_pkg::REG_BLOCK_SIZE:    block_size_q    <= pwdata[10:0];
				fcc_pkg::REG_TABLE_ENTRIES: table_entries_q <= pwdata[12:0];
				fcc_pkg::REG_FILE_COUNT:    file_count_q    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// command handshake
	logic cmd_acc;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && (state_q == S_IDLE);

	// walk step decode
	logic [5:0]  id;
	logic [5:0]  owner;
	logic [5:0]  owner_m1;
	logic [5:0]  visit;
	logic        visit_hit;
	logic        in_range;
	logic        clear_go;
	logic signed [32:0] rem_plus;
	assign id        = f_q + 6'd1;
	assign owner     = mark_rd_q[11:6];
	assign owner_m1  = owner - 6'd1;
	assign visit     = mark_rd_q[5:0];
	assign visit_hit = (visit == id);
	assign in_range  = !cur_q[12] && ({1'b0, cur_q[11:0]} < n_q);
	assign clear_go  = (idx_q < n_q);
	assign rem_plus  = rem_q + $signed({22'd0, block_size_q});

	// memory controls
	logic        link_we;
	logic        mark_we;
	logic [11:0] mark_addr;
	logic [11:0] mark_wdata;
	assign link_we = cmd_acc && (cmd.opcode == fcc_pkg::OP_LINK);
	always_comb begin
		mark_we    = 1'b0;
		mark_addr  = cur_q[11:0];
		mark_wdata = {(owner != 6'd0) ? owner : id, id};
		if (state_q == S_CLEAR) begin
			mark_we    = clear_go;
			mark_addr  = idx_q[11:0];
			mark_wdata = 12'd0;
		end else if (state_q == S_LOOK) begin
			mark_we = !visit_hit;
		end
	end

	// link and mark memories
	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[cmd.slot] <= cmd.next_link;
		if (mark_we)
			mark_mem[mark_addr] <= mark_wdata;
		link_rd_q <= link_mem[cur_q[11:0]];
		mark_rd_q <= mark_mem[mark_addr];
	end

	// directory store
	always_ff @(posedge clk) begin
		if (cmd_acc && (cmd.opcode == fcc_pkg::OP_FILE)
				&& (cmd.slot < 12'(fcc_pkg::MAX_FILES))) begin
			start_q[cmd.slot[4:0]] <= cmd.first_block;
			len_q[cmd.slot[4:0]]   <= cmd.file_bytes;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			n_q         <= '0;
			files_q     <= '0;
			f_q         <= '0;
			cur_q       <= '0;
			rem_q       <= '0;
			reached_q   <= '0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_fvalid_q <= 1'b0;
			out_flags_q <= '0;
			out_free_q  <= '0;
			out_last_q  <= 1'b0;
			for (int i = 0; i < fcc_pkg::MAX_FILES; i++)
				flags_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_acc && (cmd.opcode == fcc_pkg::OP_CHECK)) begin
						n_q       <= (table_entries_q > 13'(fcc_pkg::TABLE_DEPTH)) ?
							13'(fcc_pkg::TABLE_DEPTH) : table_entries_q;
						files_q   <= (file_count_q > 6'(fcc_pkg::MAX_FILES)) ?
							6'(fcc_pkg::MAX_FILES) : file_count_q;
						idx_q     <= '0;
						f_q       <= '0;
						reached_q <= '0;
						for (int i = 0; i < fcc_pkg::MAX_FILES; i++)
							flags_q[i] <= '0;
						state_q <= S_CLEAR;
					end
				end
				// sweep the marks of the entries in use
				S_CLEAR: begin
					if (clear_go)
						idx_q <= idx_q + 13'd1;
					else
						state_q <= S_FILE;
				end
				S_FILE: begin
					if (f_q == files_q) begin
						f_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						cur_q   <= start_q[f_q[4:0]];
						rem_q   <= $signed({2'd0, len_q[f_q[4:0]]});
						state_q <= S_WALK;
					end
				end
				// wait for the registered memory reads of cur
				S_WALK: begin
					state_q <= in_range ? S_LOOK : S_FINISH;
				end
				S_LOOK: begin
					if (visit_hit) begin
						flags_q[f_q[4:0]][fcc_pkg::FLAG_CYCLE] <= 1'b1;
						state_q <= S_FINISH;
					end else begin
						if (owner != 6'd0) begin
							flags_q[f_q[4:0]][fcc_pkg::FLAG_SHARE]      <= 1'b1;
							flags_q[owner_m1[4:0]][fcc_pkg::FLAG_SHARE] <= 1'b1;
						end else begin
							reached_q <= reached_q + 13'd1;
						end
						rem_q   <= rem_q - $signed({22'd0, block_size_q});
						cur_q   <= link_rd_q;
						state_q <= S_WALK;
					end
				end
				// size check on what is left
				S_FINISH: begin
					if (rem_q > 33'sd0)
						flags_q[f_q[4:0]][fcc_pkg::FLAG_FEW] <= 1'b1;
					else if (rem_plus <= 33'sd0)
						flags_q[f_q[4:0]][fcc_pkg::FLAG_MANY] <= 1'b1;
					f_q     <= f_q + 6'd1;
					state_q <= S_FILE;
				end
				S_EMIT: begin
					out_valid_q <= 1'b1;
					out_index_q <= f_q[4:0];
					if (files_q == 6'd0) begin
						out_fvalid_q <= 1'b0;
						out_flags_q  <= '0;
						out_free_q   <= n_q - reached_q;
						out_last_q   <= 1'b1;
					end else begin
						out_fvalid_q <= 1'b1;
						out_flags_q  <= flags_q[f_q[4:0]];
						out_last_q   <= (f_q + 6'd1 == files_q);
						out_free_q   <= (f_q + 6'd1 == files_q) ? (n_q - reached_q) : 13'd0;
					end
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (res.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= S_IDLE;
						end else begin
							f_q     <= f_q + 6'd1;
							state_q <= S_EMIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word
	assign res.valid           = out_valid_q;
	assign res.file_index      = out_index_q;
	assign res.file_valid      = out_fvalid_q;
	assign res.too_few_blocks  = out_flags_q[fcc_pkg::FLAG_FEW];
	assign res.too_many_blocks = out_flags_q[fcc_pkg::FLAG_MANY];
	assign res.contains_cycle  = out_flags_q[fcc_pkg::FLAG_CYCLE];
	assign res.shares_blocks   = out_flags_q[fcc_pkg::FLAG_SHARE];
	assign res.free_blocks     = out_free_q;
	assign res.last            = out_last_q;

endmodule
`default_nettype wire

FILE: verif/fat_chain_consistency_checker_tb.sv
`timescale 1ns / 1ps
module fat_chain_consistency_checker_tb;

	typedef struct {
		fcc_pkg::opcode_t   op;
		logic [11:0]        slot;
		logic signed [12:0] next_link;
		logic signed [12:0] first_block;
		logic [30:0]        file_bytes;
	} cmd_word_t;

	typedef struct {
		logic [4:0]  file_index;
		logic        file_valid;
		logic        too_few;
		logic        too_many;
		logic        has_cycle;
		logic        shares;
		logic [12:0] free_blocks;
		logic        last;
	} file_report_t;

	// allocation table and directory mirror, walks chains to predict reports
	class fat_check_model;
		int bs;
		int te;
		int fc;
		int link_tab[fcc_pkg::TABLE_DEPTH];
		bit link_set[fcc_pkg::TABLE_DEPTH];
		int start_tab[fcc_pkg::MAX_FILES];
		longint len_tab[fcc_pkg::MAX_FILES];
		bit file_set[fcc_pkg::MAX_FILES];
		file_report_t pending_reports[$];

		function new();
			bs = 512;
			te = 4096;
			fc = 0;
		endfunction

		function void set_reg(logic [1:0] idx, int v);
			case (idx)
				fcc_pkg::REG_BLOCK_SIZE: bs = v & 'h7FF;
				fcc_pkg::REG_TABLE_ENTRIES: te = v & 'h1FFF;
				fcc_pkg::REG_FILE_COUNT: fc = v & 'h3F;
				default: ;
			endcase
		endfunction

		function int table_size();
			return te < fcc_pkg::TABLE_DEPTH ? te : fcc_pkg::TABLE_DEPTH;
		endfunction

		function int dir_size();
			return fc < fcc_pkg::MAX_FILES ? fc : fcc_pkg::MAX_FILES;
		endfunction

		// walk every chain; in probe mode return the first unloaded block met
		function int walk_chains(bit probe);
			int n, files, reached, cur, b, id, f;
			longint rem;
			byte unsigned owner[fcc_pkg::TABLE_DEPTH];
			byte unsigned mark[fcc_pkg::TABLE_DEPTH];
			bit [3:0] flags[fcc_pkg::MAX_FILES];
			file_report_t r;
			n = table_size();
			files = dir_size();
			reached = 0;
			foreach (owner[i]) begin
				owner[i] = 0;
				mark[i] = 0;
			end
			foreach (flags[i]) flags[i] = 0;
			for (f = 0; f < files; f++) begin
				cur = start_tab[f];
				rem = len_tab[f];
				id = f + 1;
				while (cur >= 0 && cur < n) begin
					b = cur;
					if (probe && !link_set[b])
						return b;
					if (mark[b] == id) begin
						flags[f][fcc_pkg::FLAG_CYCLE] = 1'b1;
						break;
					end
					if (owner[b] != 0) begin
						flags[f][fcc_pkg::FLAG_SHARE] = 1'b1;
						flags[owner[b] - 1][fcc_pkg::FLAG_SHARE] = 1'b1;
					end else begin
						owner[b] = id;
						reached++;
					end
					mark[b] = id;
					rem -= bs;
					cur = link_tab[b];
				end
				if (rem <= 0) begin
					if (rem + bs <= 0)
						flags[f][fcc_pkg::FLAG_MANY] = 1'b1;
				end else begin
					flags[f][fcc_pkg::FLAG_FEW] = 1'b1;
				end
			end
			if (probe)
				return -1;
			if (files == 0) begin
				r = '{5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'(n - reached), 1'b1};
				pending_reports = {pending_reports, r};
			end
			for (f = 0; f < files; f++) begin
				r.file_index = 5'(f);
				r.file_valid = 1'b1;
				r.too_few = flags[f][fcc_pkg::FLAG_FEW];
				r.too_many = flags[f][fcc_pkg::FLAG_MANY];
				r.has_cycle = flags[f][fcc_pkg::FLAG_CYCLE];
				r.shares = flags[f][fcc_pkg::FLAG_SHARE];
				r.last = (f + 1 == files);
				r.free_blocks = r.last ? 13'(n - reached) : 13'd0;
				pending_reports = {pending_reports, r};
			end
			return -1;
		endfunction

		function void note_cmd(cmd_word_t c);
			case (c.op)
				fcc_pkg::OP_LINK: begin
					link_tab[c.slot] = c.next_link;
					link_set[c.slot] = 1'b1;
				end
				fcc_pkg::OP_FILE: if (c.slot < fcc_pkg::MAX_FILES) begin
					start_tab[c.slot] = c.first_block;
					len_tab[c.slot] = c.file_bytes;
					file_set[c.slot] = 1'b1;
				end
				fcc_pkg::OP_CHECK: void'(walk_chains(1'b0));
				default: ;
			endcase
		endfunction

		// returns a mask of mismatching fields, orphan when nothing was due
		function bit [7:0] check_report(file_report_t got, output file_report_t want,
				output bit orphan);
			bit [7:0] bad;
			orphan = (pending_reports.size() == 0);
			if (orphan)
				return 8'h00;
			want = pending_reports.pop_front();
			bad[0] = got.file_index !== want.file_index;
			bad[1] = got.file_valid !== want.file_valid;
			bad[2] = got.too_few !== want.too_few;
			bad[3] = got.too_many !== want.too_many;
			bad[4] = got.has_cycle !== want.has_cycle;
			bad[5] = got.shares !== want.shares;
			bad[6] = got.free_blocks !== want.free_blocks;
			bad[7] = got.last !== want.last;
			return bad;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	fcc_cmd_if cmd ();
	fcc_res_if res ();

	fat_chain_consistency_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.res(res.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	fat_check_model chk_model;
	int error_count;
	int words_sent;
	bit calm;
	bit hold_req;
	int hold_left;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	initial begin
		#200000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task report(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// receiver: random stalls plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			res.ready <= 1'b0;
			hold_left <= 400;
		end else if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			res.ready <= calm || ($urandom_range(99) >= 27);
		end
	end

	// result monitor
	always @(posedge clk) begin
		file_report_t got, want;
		bit [7:0] bad;
		bit orphan;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.file_index, res.file_valid, res.too_few_blocks, res.too_many_blocks,
				res.contains_cycle, res.shares_blocks, res.free_blocks, res.last};
			bad = chk_model.check_report(got, want, orphan);
			if (orphan)
				report($sformatf("unexpected word for file %0d", got.file_index));
			else if (bad != 0)
				report($sformatf("file %0d fields %b got %p want %p",
					want.file_index, bad, got, want));
		end
	end

	function cmd_word_t mk(fcc_pkg::opcode_t op, int slot, int nl, int fb, longint bytes);
		cmd_word_t c;
		c.op = op;
		c.slot = 12'(slot);
		c.next_link = 13'(nl);
		c.first_block = 13'(fb);
		c.file_bytes = 31'(bytes);
		return c;
	endfunction

	// one command word, with an optional idle gap before it
	task send(cmd_word_t c);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 27 && gap < 6)
				gap++;
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.opcode <= c.op;
		cmd.slot <= c.slot;
		cmd.next_link <= c.next_link;
		cmd.first_block <= c.first_block;
		cmd.file_bytes <= c.file_bytes;
		do @(posedge clk); while (!cmd.ready);
		chk_model.note_cmd(c);
		words_sent++;
	endtask

	task drain();
		cmd.valid <= 1'b0;
		while (chk_model.pending_reports.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, int v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		chk_model.set_reg(idx, v);
	endtask

	// link value: end marks, out-of-range values or blocks of the table
	function int pick_link();
		int n, r;
		n = chk_model.table_size();
		r = $urandom_range(99);
		if (r < 22 || n == 0)
			return -1;
		if (r < 28)
			return -int'($urandom_range(4096, 2));
		if (r < 34 && n < fcc_pkg::TABLE_DEPTH)
			return $urandom_range(4095, n);
		if (r < 37)
			return $urandom_range(4095);
		return $urandom_range(n - 1);
	endfunction

	// chain of up to four blocks for one file, its size mostly near its block count
	task make_file(int f);
		int n, len, blk[5];
		longint base, bytes;
		n = chk_model.table_size();
		len = (n == 0) ? 0 : $urandom_range(4);
		for (int i = 0; i < len; i++)
			blk[i] = $urandom_range(n - 1);
		for (int i = 0; i + 1 < len; i++)
			send(mk(fcc_pkg::OP_LINK, blk[i], blk[i + 1], 0, $urandom));
		if (len > 0)
			send(mk(fcc_pkg::OP_LINK, blk[len - 1], pick_link(), 0, $urandom));
		base = longint'(len) * chk_model.bs;
		case ($urandom_range(5))
			0: bytes = base;
			1: bytes = base - $urandom_range(chk_model.bs);
			2: bytes = base + 1;
			3: bytes = base - chk_model.bs;
			4: bytes = base + chk_model.bs + $urandom_range(9);
			default: bytes = {$urandom} & 'h7FFFFFFF;
		endcase
		if (bytes < 0)
			bytes = 0;
		if (bytes > 'h7FFFFFFF)
			bytes = 'h7FFFFFFF;
		send(mk(fcc_pkg::OP_FILE, f, $urandom, len > 0 ? blk[0] : pick_link(), bytes));
	endtask

	// load every entry the walk would read, then start the check
	task run_check();
		int m;
		for (int f = 0; f < chk_model.dir_size(); f++)
			if (!chk_model.file_set[f])
				send(mk(fcc_pkg::OP_FILE, f, 0, pick_link(), $urandom_range(4096)));
		m = chk_model.walk_chains(1'b1);
		while (m >= 0) begin
			send(mk(fcc_pkg::OP_LINK, m, pick_link(), 0, 0));
			m = chk_model.walk_chains(1'b1);
		end
		send(mk(fcc_pkg::OP_CHECK, $urandom, $urandom, $urandom, $urandom));
	endtask

	initial begin
		int r, files;
		chk_model = new();
		error_count = 0;
		words_sent = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd.valid = 1'b0;
		cmd.opcode = fcc_pkg::OP_NONE;
		cmd.slot = '0;
		cmd.next_link = '0;
		cmd.first_block = '0;
		cmd.file_bytes = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty directory, ignored words, edge values of each field
		send(mk(fcc_pkg::OP_CHECK, 0, 0, 0, 0));
		send(mk(fcc_pkg::OP_NONE, 4095, -1, -1, 'h7FFFFFFF));
		send(mk(fcc_pkg::OP_FILE, 4095, 0, 0, 'h7FFFFFFF));
		send(mk(fcc_pkg::OP_LINK, 4095, 4095, 0, 0));
		drain();
		write_reg(fcc_pkg::REG_BLOCK_SIZE, 1);
		write_reg(fcc_pkg::REG_TABLE_ENTRIES, 8);
		write_reg(fcc_pkg::REG_FILE_COUNT, 4);
		// exact chain, shared tail, self loop, empty file
		send(mk(fcc_pkg::OP_LINK, 0, 1, 0, 0));
		send(mk(fcc_pkg::OP_LINK, 1, -1, 0, 0));
		send(mk(fcc_pkg::OP_LINK, 2, 2, 0, 0));
		send(mk(fcc_pkg::OP_LINK, 3, 4095, 0, 0));
		send(mk(fcc_pkg::OP_FILE, 0, 0, 0, 2));
		send(mk(fcc_pkg::OP_FILE, 1, 0, 1, 'h7FFFFFFF));
		send(mk(fcc_pkg::OP_FILE, 2, 0, 2, 0));
		send(mk(fcc_pkg::OP_FILE, 3, 0, -1, 0));
		send(mk(fcc_pkg::OP_CHECK, 0, 0, 0, 0));
		drain();
		// zero block size, link beyond a one-entry table
		write_reg(fcc_pkg::REG_BLOCK_SIZE, 0);
		write_reg(fcc_pkg::REG_TABLE_ENTRIES, 1);
		write_reg(fcc_pkg::REG_FILE_COUNT, 2);
		send(mk(fcc_pkg::OP_FILE, 1, 0, 3, 5));
		run_check();
		drain();
		write_reg(fcc_pkg::REG_BLOCK_SIZE, 2047);
		write_reg(fcc_pkg::REG_TABLE_ENTRIES, 8);
		write_reg(fcc_pkg::REG_FILE_COUNT, 3);
		send(mk(fcc_pkg::OP_LINK, 3, -4096, 0, 0));
		send(mk(fcc_pkg::OP_FILE, 2, 0, 3, 2047));
		run_check();

		// random phases of loads followed by a check
		while (words_sent < 430) begin
			drain();
			calm = ($urandom_range(9) == 0);
			r = $urandom_range(19);
			case (r)
				0: write_reg(fcc_pkg::REG_TABLE_ENTRIES, 4096);
				1: write_reg(fcc_pkg::REG_TABLE_ENTRIES, 8191);
				2: write_reg(fcc_pkg::REG_TABLE_ENTRIES, 0);
				3: write_reg(fcc_pkg::REG_TABLE_ENTRIES, 1);
				default: write_reg(fcc_pkg::REG_TABLE_ENTRIES, $urandom_range(40, 2));
			endcase
			r = $urandom_range(15);
			case (r)
				0: write_reg(fcc_pkg::REG_BLOCK_SIZE, 0);
				1: write_reg(fcc_pkg::REG_BLOCK_SIZE, 1024);
				2: write_reg(fcc_pkg::REG_BLOCK_SIZE, 2047);
				default: write_reg(fcc_pkg::REG_BLOCK_SIZE, $urandom_range(64, 1));
			endcase
			r = $urandom_range(15);
			case (r)
				0: write_reg(fcc_pkg::REG_FILE_COUNT, 0);
				1: write_reg(fcc_pkg::REG_FILE_COUNT, 32);
				2: write_reg(fcc_pkg::REG_FILE_COUNT, 63);
				default: write_reg(fcc_pkg::REG_FILE_COUNT, $urandom_range(6, 1));
			endcase
			files = chk_model.dir_size();
			repeat ($urandom_range(4, 1)) begin
				r = $urandom_range(9);
				if (r < 7)
					make_file(files > 0 ? $urandom_range(files - 1) : $urandom_range(31));
				else if (r == 7)
					send(mk(fcc_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom));
				else if (r == 8)
					send(mk(fcc_pkg::OP_FILE, $urandom_range(4095, 32), $urandom, $urandom,
						$urandom));
				else
					send(mk(fcc_pkg::OP_LINK, $urandom, pick_link(), $urandom, $urandom));
			end
			if (words_sent < 60 || $urandom_range(7) == 0) begin
				// long receiver hold while loads keep coming behind the check
				hold_req = 1'b1;
				run_check();
				make_file(files > 0 ? $urandom_range(files - 1) : 0);
				make_file(files > 0 ? $urandom_range(files - 1) : 0);
			end else begin
				run_check();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: fat_chain_consistency_checker.f
design/fcc_pkg.sv
design/fcc_cmd_if.sv
design/fcc_res_if.sv
design/fat_chain_consistency_checker.sv
verif/fat_chain_consistency_checker_tb.sv
